// ----- hw/rtl/spq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types, codes and helpers of the stable priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int PRIO_BITS   = 4;
    localparam int OUT_TAG_BITS = 16;

    localparam logic [1:0] OP_INSERT    = 2'd0;
    localparam logic [1:0] OP_SERVE     = 2'd1;
    localparam logic [1:0] OP_SERVE_ALL = 2'd2;

    localparam logic [1:0] STATUS_SERVED   = 2'd0;
    localparam logic [1:0] STATUS_EMPTY    = 2'd1;
    localparam logic [1:0] STATUS_INSERTED = 2'd2;
    localparam logic [1:0] STATUS_DROPPED  = 2'd3;

    localparam logic [1:0] CLASS_VVIP    = 2'd0;
    localparam logic [1:0] CLASS_VIP     = 2'd1;
    localparam logic [1:0] CLASS_REGULAR = 2'd2;
    localparam logic [1:0] CLASS_NONE    = 2'd3;

    localparam logic [PRIO_BITS-1:0] PRIO_VVIP      = 4'd1;
    localparam logic [PRIO_BITS-1:0] PRIO_VIP       = 4'd2;
    localparam logic [PRIO_BITS-1:0] PRIO_REGULAR_A = 4'd3;
    localparam logic [PRIO_BITS-1:0] PRIO_REGULAR_B = 4'd4;

    typedef struct packed {
        logic insert;
        logic pop;
    } spq_ctrl_t;

    function automatic logic [1:0] class_of(input logic [PRIO_BITS-1:0] prio);
        logic [1:0] cls;
        if (prio == PRIO_VVIP) begin
            cls = CLASS_VVIP;
        end else if (prio == PRIO_VIP) begin
            cls = CLASS_VIP;
        end else if (prio == PRIO_REGULAR_A || prio == PRIO_REGULAR_B) begin
            cls = CLASS_REGULAR;
        end else begin
            cls = CLASS_NONE;
        end
        return cls;
    endfunction

endpackage

// ----- hw/rtl/stable_priority_queue_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stable_priority_queue_top
// Bounded stable priority queue built as a sorted chain of slot cells.
// ----------------------------------------------------------------------------
// A request on the s_ channel carries an opcode in s_tuser: insert, serve the
// head, or serve all entries. Each slot cell compares its priority with the
// new one and, on an insert, keeps, takes the new entry or takes its left
// neighbor; a pop moves every cell one place toward the head.
// Results leave on the m_ channel through an output register: status in
// m_tuser, the served entry and its class in m_tdata, m_tlast on the final
// result of a request.
// Insert and serve give their single result in the cycle after acceptance.
// Serve-all gives one result per stored entry, or an empty result if none,
// one per cycle while m_tready does not stall, and takes no new request until
// the last one is registered. The unused opcode is taken and gives no result.
// A request is taken when no serve-all drains and the output register is free
// or read in the same cycle; an m_tready stall holds the result and s_tready.
// A synchronous reset empties the queue and clears m_tvalid and the drain flag.
// ----------------------------------------------------------------------------
module stable_priority_queue_top #(
    parameter int QUEUE_DEPTH = 16,
    parameter int TAG_BITS    = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [3:0] priority_req, [19:4] customer_tag
    input  logic [1:0]  s_tuser,   // [1:0] opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [3:0] served_priority, [19:4] served_tag,
                                   // [21:20] service_class
    output logic [1:0]  m_tuser,   // [1:0] status
    output logic        m_tlast
);

    localparam int PB = spq_pkg::PRIO_BITS;
    localparam int OB = spq_pkg::OUT_TAG_BITS;

    logic                valid_w [QUEUE_DEPTH];
    logic                keep_w  [QUEUE_DEPTH];
    logic [PB-1:0]       prio_w  [QUEUE_DEPTH];
    logic [TAG_BITS-1:0] tag_w   [QUEUE_DEPTH];

    spq_pkg::spq_ctrl_t  ctrl;

    logic [PB-1:0]         in_prio;
    logic [OB-1:0]         in_tag;
    logic [1:0]            in_op;
    logic [TAG_BITS+OB-1:0] in_tag_ext;
    logic [TAG_BITS-1:0]   new_tag;
    logic [TAG_BITS+OB-1:0] head_tag_ext;
    logic [OB-1:0]         head_tag;

    logic          m_tvalid_reg, m_tvalid_next;
    logic [1:0]    status_reg, status_next;
    logic [PB-1:0] sprio_reg, sprio_next;
    logic [OB-1:0] stag_reg, stag_next;
    logic [1:0]    class_reg, class_next;
    logic          last_reg, last_next;
    logic          drain_reg, drain_next;

    logic out_free, s_accept, drain_step, full, empty, is_serve;

    assign in_prio    = s_tdata[3:0];
    assign in_tag     = s_tdata[19:4];
    assign in_op      = s_tuser;
    assign in_tag_ext = {{TAG_BITS{1'b0}}, in_tag};
    assign new_tag    = in_tag_ext[TAG_BITS-1:0];

    assign head_tag_ext = {{OB{1'b0}}, tag_w[0]};
    assign head_tag     = head_tag_ext[OB-1:0];

    assign full     = valid_w[QUEUE_DEPTH-1];
    assign empty    = !valid_w[0];
    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = !drain_reg && out_free;
    assign s_accept = s_tvalid && s_tready;
    assign drain_step = drain_reg && out_free;
    assign is_serve = (in_op == spq_pkg::OP_SERVE) || (in_op == spq_pkg::OP_SERVE_ALL);

    assign ctrl.insert = s_accept && (in_op == spq_pkg::OP_INSERT) && !full;
    assign ctrl.pop    = (s_accept && is_serve && !empty) || drain_step;

    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
            logic                lk, lv, rv;
            logic [PB-1:0]       lp, rp;
            logic [TAG_BITS-1:0] lt, rt;
            if (gi == 0) begin : g_first
                assign lk = 1'b1;
                assign lv = 1'b0;
                assign lp = '0;
                assign lt = '0;
            end else begin : g_mid
                assign lk = keep_w[gi-1];
                assign lv = valid_w[gi-1];
                assign lp = prio_w[gi-1];
                assign lt = tag_w[gi-1];
            end
            if (gi == QUEUE_DEPTH-1) begin : g_last
                assign rv = 1'b0;
                assign rp = '0;
                assign rt = '0;
            end else begin : g_inner
                assign rv = valid_w[gi+1];
                assign rp = prio_w[gi+1];
                assign rt = tag_w[gi+1];
            end
            spq_cell #(
                .TAG_BITS(TAG_BITS)
            ) u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .ctrl       (ctrl),
                .new_prio   (in_prio),
                .new_tag    (new_tag),
                .left_keep  (lk),
                .left_valid (lv),
                .left_prio  (lp),
                .left_tag   (lt),
                .right_valid(rv),
                .right_prio (rp),
                .right_tag  (rt),
                .keep       (keep_w[gi]),
                .valid      (valid_w[gi]),
                .prio       (prio_w[gi]),
                .tag        (tag_w[gi])
            );
        end
    endgenerate

    always_comb begin
        m_tvalid_next = m_tvalid_reg && !m_tready;
        status_next   = status_reg;
        sprio_next    = sprio_reg;
        stag_next     = stag_reg;
        class_next    = class_reg;
        last_next     = last_reg;
        drain_next    = drain_reg;
        if (drain_step || (s_accept && is_serve && !empty)) begin
            m_tvalid_next = 1'b1;
            status_next   = spq_pkg::STATUS_SERVED;
            sprio_next    = prio_w[0];
            stag_next     = head_tag;
            class_next    = spq_pkg::class_of(prio_w[0]);
            last_next     = (in_op == spq_pkg::OP_SERVE && !drain_reg) || !valid_w[1];
            drain_next    = !last_next;
        end else if (s_accept) begin
            sprio_next = '0;
            stag_next  = '0;
            class_next = spq_pkg::CLASS_NONE;
            last_next  = 1'b1;
            case (in_op)
                spq_pkg::OP_INSERT: begin
                    m_tvalid_next = 1'b1;
                    status_next   = full ? spq_pkg::STATUS_DROPPED
                                         : spq_pkg::STATUS_INSERTED;
                end
                spq_pkg::OP_SERVE, spq_pkg::OP_SERVE_ALL: begin
                    m_tvalid_next = 1'b1;
                    status_next   = spq_pkg::STATUS_EMPTY;
                end
                default: begin
                    m_tvalid_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
            drain_reg    <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
            drain_reg    <= drain_next;
        end
    end

    always_ff @(posedge aclk) begin
        status_reg <= status_next;
        sprio_reg  <= sprio_next;
        stag_reg   <= stag_next;
        class_reg  <= class_next;
        last_reg   <= last_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = status_reg;
    assign m_tlast  = last_reg;
    assign m_tdata  = {2'b00, class_reg, stag_reg, sprio_reg};

endmodule

// ----- hw/rtl/spq_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain: keeps, takes the new entry, or shifts.
// ----------------------------------------------------------------------------
module spq_cell #(
    parameter int TAG_BITS = 16
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  spq_pkg::spq_ctrl_t               ctrl,
    input  logic [spq_pkg::PRIO_BITS-1:0]    new_prio,
    input  logic [TAG_BITS-1:0]              new_tag,
    input  logic                             left_keep,
    input  logic                             left_valid,
    input  logic [spq_pkg::PRIO_BITS-1:0]    left_prio,
    input  logic [TAG_BITS-1:0]              left_tag,
    input  logic                             right_valid,
    input  logic [spq_pkg::PRIO_BITS-1:0]    right_prio,
    input  logic [TAG_BITS-1:0]              right_tag,
    output logic                             keep,
    output logic                             valid,
    output logic [spq_pkg::PRIO_BITS-1:0]    prio,
    output logic [TAG_BITS-1:0]              tag
);

    logic                          valid_reg, valid_next;
    logic [spq_pkg::PRIO_BITS-1:0] prio_reg, prio_next;
    logic [TAG_BITS-1:0]           tag_reg, tag_next;

    assign keep = valid_reg && (prio_reg <= new_prio);

    always_comb begin
        valid_next = valid_reg;
        prio_next  = prio_reg;
        tag_next   = tag_reg;
        if (ctrl.insert) begin
            if (!keep) begin
                if (left_keep) begin
                    valid_next = 1'b1;
                    prio_next  = new_prio;
                    tag_next   = new_tag;
                end else begin
                    valid_next = left_valid;
                    prio_next  = left_prio;
                    tag_next   = left_tag;
                end
            end
        end else if (ctrl.pop) begin
            valid_next = right_valid;
            prio_next  = right_prio;
            tag_next   = right_tag;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        prio_reg <= prio_next;
        tag_reg  <= tag_next;
    end

    assign valid = valid_reg;
    assign prio  = prio_reg;
    assign tag   = tag_reg;

endmodule

// ----- hw/rtl/spq_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_checker
// Port-level checks of the stable priority queue, bound to the top level.
// ----------------------------------------------------------------------------
module spq_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [1:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("Stalled result changed.");

    a_single_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != spq_pkg::STATUS_SERVED) |-> m_tlast)
        else $error("A non-serving result is not marked last.");

    a_blank: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != spq_pkg::STATUS_SERVED)
            |-> (m_tdata[19:0] == 20'd0) && (m_tdata[21:20] == spq_pkg::CLASS_NONE))
        else $error("A non-serving result carries entry data.");

    a_insert_answer: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == spq_pkg::OP_INSERT)
            |=> m_tvalid && ((m_tuser == spq_pkg::STATUS_INSERTED)
                || (m_tuser == spq_pkg::STATUS_DROPPED)))
        else $error("An insert request got no insert result.");

endmodule

bind stable_priority_queue_top spq_checker u_spq_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast)
);
